// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer RTL.
// Each macro wraps one concurrent assertion clocked on the given clock
// and disabled while the given active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("property check failed");

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/cyrmt_pkg.sv =====
// Shared constants and types of the cycling relay minute timer.
// No dependencies; every other file of the block but assert_macros.svh imports it.
`default_nettype none

package cyrmt_pkg;

	localparam int TICKS_PER_SECOND = 61;
	localparam int MAX_MINUTES      = 99;
	localparam int SECONDS_LAST     = 60;

	localparam int DIP_W   = 4;
	localparam int TICK_W  = $clog2(TICKS_PER_SECOND);
	localparam int SEC_W   = $clog2(SECONDS_LAST + 1);
	localparam int MIN_W   = $clog2(MAX_MINUTES + 1);
	localparam int BLINK_W = 7;

	// Blink bits picked for the slow and the fast LED rate.
	localparam int BLINK_SLOW_BIT = 6;
	localparam int BLINK_FAST_BIT = 3;

	// Counts after the tick has advanced, before the buttons act.
	typedef struct packed {
		logic [BLINK_W-1:0] blink;
		logic [MIN_W-1:0]   minutes;
	} cyrmt_view_t;

	typedef struct packed {
		logic relay;
		logic led;
	} cyrmt_result_t;

endpackage

`default_nettype wire

// ===== hdl/cyrmt_counters.sv =====
// Blink, tick, second and minute counters of the timer, with button effects.
// Depends on cyrmt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cyrmt_counters
	import cyrmt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick_en,
	input  wire logic              hold,
	input  wire logic              start,
	output cyrmt_view_t            view
);

	logic [BLINK_W-1:0] blink_q;
	logic [TICK_W-1:0]  tick_q;
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;

	logic [BLINK_W-1:0] blink_n;
	logic [TICK_W-1:0]  tick_n;
	logic [SEC_W-1:0]   sec_adv;
	logic [SEC_W-1:0]   sec_n;
	logic [MIN_W-1:0]   min_n;

	always_comb begin
		blink_n = blink_q + BLINK_W'(1);
		if (tick_q == TICK_W'(TICKS_PER_SECOND - 1)) begin
			tick_n = '0;
		end else begin
			tick_n = tick_q + TICK_W'(1);
		end
		sec_adv = sec_q;
		if (tick_n == TICK_W'(TICKS_PER_SECOND - 1)) begin
			if (sec_q == SEC_W'(SECONDS_LAST)) begin
				sec_adv = '0;
			end else begin
				sec_adv = sec_q + SEC_W'(1);
			end
		end
		sec_n = sec_adv;
		min_n = min_q;
		// A full second-count rolls into the next minute unless finished.
		if (sec_adv == SEC_W'(SECONDS_LAST) && tick_n == '0 &&
				min_q < MIN_W'(MAX_MINUTES)) begin
			min_n = min_q + MIN_W'(1);
			sec_n = '0;
		end
	end

	assign view.blink   = blink_n;
	assign view.minutes = min_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= '0;
			tick_q  <= '0;
			sec_q   <= '0;
			min_q   <= MIN_W'(MAX_MINUTES);
		end else if (tick_en) begin
			blink_q <= blink_n;
			if (start) begin
				tick_q <= '0;
				sec_q  <= '0;
				min_q  <= '0;
			end else begin
				tick_q <= tick_n;
				sec_q  <= sec_n;
				min_q  <= hold ? MIN_W'(MAX_MINUTES) : min_n;
			end
		end
	end

	`ASSERT_NEVER(a_tick_range, clk, arst_n, tick_q > TICK_W'(TICKS_PER_SECOND - 1))
	`ASSERT_NEVER(a_min_range, clk, arst_n, min_q > MIN_W'(MAX_MINUTES))
	`ASSERT_PROP(a_start_clears, clk, arst_n, (tick_en && start) |=> (min_q == '0 && sec_q == '0 && tick_q == '0))
	`ASSERT_PROP(a_hold_finishes, clk, arst_n, (tick_en && hold && !start) |=> (min_q == MIN_W'(MAX_MINUTES)))

endmodule

`default_nettype wire

// ===== hdl/cyrmt_decode.sv =====
// Relay schedule and LED rate decode from the advanced minute and blink counts.
// Depends on cyrmt_pkg.
`default_nettype none

module cyrmt_decode
	import cyrmt_pkg::*;
(
	input  wire logic [DIP_W-1:0] dip,
	input  wire cyrmt_view_t      view,
	output cyrmt_result_t         result
);

	// End time is 2.5 * dip rounded down; the relay pauses from dip to 1.5 * dip.
	logic [DIP_W+1:0] end_time;
	logic [DIP_W:0]   resume;
	logic [MIN_W-1:0] end_ext;
	logic [MIN_W-1:0] resume_ext;
	logic [MIN_W-1:0] dip_ext;

	always_comb begin
		end_time   = {1'b0, dip, 1'b0} + (DIP_W+2)'(dip >> 1);
		resume     = {1'b0, dip} + (DIP_W+1)'(dip >> 1);
		end_ext    = MIN_W'(end_time);
		resume_ext = MIN_W'(resume);
		dip_ext    = MIN_W'(dip);
		result.relay = (view.minutes < dip_ext) ||
			(view.minutes >= resume_ext && view.minutes < end_ext);
		result.led = (view.minutes >= end_ext) ? view.blink[BLINK_SLOW_BIT]
			: view.blink[BLINK_FAST_BIT];
	end

endmodule

`default_nettype wire

// ===== hdl/cycling_relay_minute_timer.sv =====
// Top level of the cycling relay minute timer: counters, decode, result register.
// Depends on cyrmt_pkg, cyrmt_counters, cyrmt_decode and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake              Payload
// tick in   input      in_valid / in_stall    dip_setting, hold_button, start_button
// result    output     out_valid / out_stall  relay_on, led_on
//
// Every request is one timer tick and yields exactly one result request.
// A tick's result is ready in the cycle after it is accepted; one tick can be
// taken every cycle while not stalled, set by the single result register after the decode.
// in_stall is raised only while the result register is full and stalled.
// Reset leaves all counts at zero except minutes, which start finished (99).
// The counters advance at the accept edge, so stalls never replay a tick.

module cycling_relay_minute_timer
	import cyrmt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [DIP_W-1:0] dip_setting,
	input  wire logic             hold_button,
	input  wire logic             start_button,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  relay_on,
	output logic                  led_on
);

	cyrmt_view_t   view;
	cyrmt_result_t result;
	cyrmt_result_t result_s1;
	logic          valid_s1;
	logic          accept;

	// The result register frees up in the same cycle its content is taken,
	// so a new tick may enter while the previous result leaves.
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	cyrmt_counters u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (accept),
		.hold    (hold_button),
		.start   (start_button),
		.view    (view)
	);

	// Outputs come from the advanced counts; buttons only touch the stored state.
	cyrmt_decode u_decode (
		.dip    (dip_setting),
		.view   (view),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
	end

	assign out_valid = valid_s1;
	assign relay_on  = result_s1.relay;
	assign led_on    = result_s1.led;

	`ASSERT_PROP(a_accept_fills, clk, arst_n, accept |=> valid_s1)
	`ASSERT_PROP(a_stall_holds, clk, arst_n, in_stall |=> (valid_s1 && $stable(result_s1)))

endmodule

`default_nettype wire
